// File: hw/rtl/cfbo_pkg.sv
// shared types, codes and the power-of-three table for the face boundary ordinal core
`timescale 1ns / 1ps

package cfbo_pkg;

  localparam int MAX_AXES_DEFAULT = 16;
  localparam int DIGIT_AXES       = 16;
  localparam int ORD_W            = 26;
  localparam int DIM_W            = 5;
  localparam int STATUS_W         = 2;

  localparam logic [1:0] DIGIT_VARYING = 2'd2;
  localparam logic [1:0] DIGIT_INVALID = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // packet that walks down the row of axis cells
  // scan pass: acc is the face ordinal, cnt counts varying axes
  // place pass: acc is the boundary ordinal, cnt is varying axes left, rest is index left
  typedef struct packed {
    logic             valid;
    logic             place;
    logic [ORD_W-1:0] acc;
    logic [ORD_W-1:0] rest;
    logic [DIM_W-1:0] cnt;
    logic             invalid;
    logic             center;
  } cfbo_pkt_t;

  function automatic logic [ORD_W-1:0] pow3(input logic [DIM_W-1:0] e);
    logic [ORD_W-1:0] p;
    case (e)
      5'd0:    p = 26'd1;
      5'd1:    p = 26'd3;
      5'd2:    p = 26'd9;
      5'd3:    p = 26'd27;
      5'd4:    p = 26'd81;
      5'd5:    p = 26'd243;
      5'd6:    p = 26'd729;
      5'd7:    p = 26'd2187;
      5'd8:    p = 26'd6561;
      5'd9:    p = 26'd19683;
      5'd10:   p = 26'd59049;
      5'd11:   p = 26'd177147;
      5'd12:   p = 26'd531441;
      5'd13:   p = 26'd1594323;
      5'd14:   p = 26'd4782969;
      5'd15:   p = 26'd14348907;
      5'd16:   p = 26'd43046721;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/cfbo_cell.sv
// one axis cell: holds the axis digit and updates the passing packet
`timescale 1ns / 1ps

module cfbo_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [1:0]           digit_in,
  input  logic                 used_in,
  input  cfbo_pkg::cfbo_pkt_t  pkt_in,
  output cfbo_pkg::cfbo_pkt_t  pkt_out
);

  logic [1:0]                  digit;
  logic                        used;
  cfbo_pkg::cfbo_pkt_t         pkt_next;
  logic [cfbo_pkg::DIM_W-1:0]  cnt_dec;
  logic [cfbo_pkg::ORD_W-1:0]  p1;
  logic [cfbo_pkg::ORD_W+1:0]  d1;
  logic [cfbo_pkg::ORD_W+1:0]  d2;
  logic [1:0]                  place_digit;
  logic [cfbo_pkg::ORD_W-1:0]  rest_sel;
  logic [1:0]                  acc_digit;
  logic [cfbo_pkg::ORD_W-1:0]  acc3;
  logic                        varying;

  always_ff @(posedge clk) begin
    if (load) begin
      digit <= digit_in;
      used  <= used_in;
    end
  end

  assign varying = (digit == cfbo_pkg::DIGIT_VARYING);

  // most significant remaining index digit, by trial subtraction of 2p and p
  assign cnt_dec = pkt_in.cnt - 5'd1;
  assign p1      = cfbo_pkg::pow3(cnt_dec);
  assign d1      = {2'b00, pkt_in.rest} - {2'b00, p1};
  assign d2      = {2'b00, pkt_in.rest} - {1'b0, p1, 1'b0};

  always_comb begin
    if (!d2[cfbo_pkg::ORD_W+1]) begin
      place_digit = 2'd2;
      rest_sel    = d2[cfbo_pkg::ORD_W-1:0];
    end else if (!d1[cfbo_pkg::ORD_W+1]) begin
      place_digit = 2'd1;
      rest_sel    = d1[cfbo_pkg::ORD_W-1:0];
    end else begin
      place_digit = 2'd0;
      rest_sel    = pkt_in.rest;
    end
  end

  assign acc_digit = (pkt_in.place && varying) ? place_digit : digit;
  assign acc3      = {pkt_in.acc[cfbo_pkg::ORD_W-2:0], 1'b0} + pkt_in.acc
                   + {{(cfbo_pkg::ORD_W-2){1'b0}}, acc_digit};

  always_comb begin
    pkt_next = pkt_in;
    if (used) begin
      pkt_next.acc = acc3;
      if (pkt_in.place) begin
        if (varying) begin
          pkt_next.cnt  = cnt_dec;
          pkt_next.rest = rest_sel;
        end
      end else begin
        if (digit == cfbo_pkg::DIGIT_INVALID) begin
          pkt_next.invalid = 1'b1;
        end
        if (varying) begin
          pkt_next.cnt = pkt_in.cnt + 5'd1;
        end else begin
          pkt_next.center = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

endmodule

// File: hw/rtl/cube_face_boundary_ordinal_core.sv
// top level: sequencer around the row of axis cells for the face boundary ordinal
`timescale 1ns / 1ps

// One item at a time. An item is taken when start is high and busy is low; the
// result comes out on the result ports with done high for exactly one cycle and
// must be captured then, as it cannot be held off. A packet walks the row of
// min(MAX_AXES, 16) axis cells twice, one cell per cycle: first to find the face
// ordinal, the varying-axis count and any invalid digit, then to place the index
// digits into the varying axes. An error item skips the place pass; busy drops in
// the cycle that done is high, so the next item may start right then.
module cube_face_boundary_ordinal_core #(
  parameter int MAX_AXES = cfbo_pkg::MAX_AXES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [cfbo_pkg::DIM_W-1:0]     face_dim,
  input  logic [31:0]                    face_digits,
  input  logic [cfbo_pkg::ORD_W-1:0]     bnd_index,
  output logic                           done,
  output logic [cfbo_pkg::STATUS_W-1:0]  status,
  output logic [cfbo_pkg::ORD_W-1:0]     face_ordinal,
  output logic [cfbo_pkg::DIM_W-1:0]     intrinsic_dim,
  output logic [cfbo_pkg::ORD_W-1:0]     boundary_total,
  output logic                           is_center,
  output logic [cfbo_pkg::ORD_W-1:0]     boundary_ordinal
);

  localparam int CELLS = (MAX_AXES < cfbo_pkg::DIGIT_AXES) ? MAX_AXES : cfbo_pkg::DIGIT_AXES;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;

  logic [1:0]                  state;
  logic                        accept;
  logic [cfbo_pkg::DIM_W-1:0]  n_sat;
  logic [cfbo_pkg::ORD_W-1:0]  index_q;
  logic [cfbo_pkg::ORD_W-1:0]  ord_q;
  logic [cfbo_pkg::DIM_W-1:0]  k_q;
  logic [cfbo_pkg::ORD_W-1:0]  tot_q;
  logic                        center_q;
  logic [cfbo_pkg::ORD_W-1:0]  tot_scan;
  cfbo_pkg::cfbo_pkt_t         inject;
  cfbo_pkg::cfbo_pkt_t         link [CELLS+1];
  cfbo_pkg::cfbo_pkt_t         exit_pkt;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign n_sat  = (face_dim > 5'(CELLS)) ? 5'(CELLS) : face_dim;

  assign link[0]  = inject;
  assign exit_pkt = link[CELLS];
  assign tot_scan = cfbo_pkg::pow3(exit_pkt.cnt) - 26'd1;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cfbo_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (accept),
      .digit_in (face_digits[2*i +: 2]),
      .used_in  (5'(i) < n_sat),
      .pkt_in   (link[i]),
      .pkt_out  (link[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      inject.valid <= 1'b0;
    end else begin
      done         <= 1'b0;
      inject.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            index_q        <= bnd_index;
            inject.valid   <= 1'b1;
            inject.place   <= 1'b0;
            inject.acc     <= '0;
            inject.rest    <= '0;
            inject.cnt     <= '0;
            inject.invalid <= 1'b0;
            inject.center  <= 1'b1;
            state          <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (exit_pkt.valid) begin
            if (exit_pkt.invalid || index_q >= tot_scan) begin
              // error items report the status with every other field zero
              status           <= exit_pkt.invalid ? cfbo_pkg::ST_BAD_DIGIT
                                                   : cfbo_pkg::ST_RANGE;
              face_ordinal     <= '0;
              intrinsic_dim    <= '0;
              boundary_total   <= '0;
              is_center        <= 1'b0;
              boundary_ordinal <= '0;
              done             <= 1'b1;
              state            <= S_IDLE;
            end else begin
              ord_q          <= exit_pkt.acc;
              k_q            <= exit_pkt.cnt;
              tot_q          <= tot_scan;
              center_q       <= exit_pkt.center;
              inject.valid   <= 1'b1;
              inject.place   <= 1'b1;
              inject.acc     <= '0;
              inject.rest    <= index_q;
              inject.cnt     <= exit_pkt.cnt;
              inject.invalid <= 1'b0;
              inject.center  <= 1'b0;
              state          <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          if (exit_pkt.valid) begin
            status           <= cfbo_pkg::ST_OK;
            face_ordinal     <= ord_q;
            intrinsic_dim    <= k_q;
            boundary_total   <= tot_q;
            is_center        <= center_q;
            boundary_ordinal <= exit_pkt.acc;
            done             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/cfbo_face_monitor.sv
// predictor and scoreboard for the face boundary ordinal core
`timescale 1ns / 1ps

module cfbo_face_monitor #(
  parameter int MAX_AXES = cfbo_pkg::MAX_AXES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [cfbo_pkg::DIM_W-1:0]    face_dim,
  input  logic [31:0]                   face_digits,
  input  logic [cfbo_pkg::ORD_W-1:0]    bnd_index,
  input  logic                          done,
  input  logic [cfbo_pkg::STATUS_W-1:0] status,
  input  logic [cfbo_pkg::ORD_W-1:0]    face_ordinal,
  input  logic [cfbo_pkg::DIM_W-1:0]    intrinsic_dim,
  input  logic [cfbo_pkg::ORD_W-1:0]    boundary_total,
  input  logic                          is_center,
  input  logic [cfbo_pkg::ORD_W-1:0]    boundary_ordinal,
  output int                            fail_count,
  output int                            outstanding
);

  localparam int AXIS_LIMIT = (MAX_AXES < cfbo_pkg::DIGIT_AXES) ? MAX_AXES
                                                                : cfbo_pkg::DIGIT_AXES;

  typedef struct {
    logic [cfbo_pkg::STATUS_W-1:0] status;
    logic [cfbo_pkg::ORD_W-1:0]    face_ordinal;
    logic [cfbo_pkg::DIM_W-1:0]    intrinsic_dim;
    logic [cfbo_pkg::ORD_W-1:0]    boundary_total;
    logic                          is_center;
    logic [cfbo_pkg::ORD_W-1:0]    boundary_ordinal;
  } face_answer_t;

  face_answer_t pending_faces[$];
  face_answer_t want;
  int           mismatches = 0;

  function automatic face_answer_t locate_boundary_face(
      input logic [cfbo_pkg::DIM_W-1:0] dim_in,
      input logic [31:0] digits,
      input logic [cfbo_pkg::ORD_W-1:0] idx);
    face_answer_t a;
    int           n;
    int           k;
    longint       ordinal;
    longint       total;
    longint       bord;
    longint       rest;
    longint       weight;
    logic [1:0]   d;
    bit           center;
    a = '{default: '0};
    n = dim_in;
    if (n > AXIS_LIMIT) n = AXIS_LIMIT;
    k = 0;
    ordinal = 0;
    total = 1;
    center = 1'b1;
    for (int i = 0; i < n; i++) begin
      d = digits[2*i +: 2];
      if (d == cfbo_pkg::DIGIT_INVALID) begin
        a.status = cfbo_pkg::ST_BAD_DIGIT;
        return a;
      end
      if (d == cfbo_pkg::DIGIT_VARYING) begin
        k++;
        total = total * 3;
      end else begin
        center = 1'b0;
      end
      ordinal = ordinal * 3 + d;
    end
    total = total - 1;
    if (longint'(idx) >= total) begin
      a.status = cfbo_pkg::ST_RANGE;
      return a;
    end
    // lowest index digit lands in the last varying axis
    rest = idx;
    weight = 1;
    bord = 0;
    for (int i = n - 1; i >= 0; i--) begin
      d = digits[2*i +: 2];
      if (d == cfbo_pkg::DIGIT_VARYING) begin
        d = 2'(rest % 3);
        rest = rest / 3;
      end
      bord = bord + weight * d;
      weight = weight * 3;
    end
    a.status           = cfbo_pkg::ST_OK;
    a.face_ordinal     = cfbo_pkg::ORD_W'(ordinal);
    a.intrinsic_dim    = cfbo_pkg::DIM_W'(k);
    a.boundary_total   = cfbo_pkg::ORD_W'(total);
    a.is_center        = center;
    a.boundary_ordinal = cfbo_pkg::ORD_W'(bord);
    return a;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_faces.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with no item pending, expected none, got status %0d",
                   $time, status);
        end else begin
          want = pending_faces.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("face_ordinal", 32'(want.face_ordinal), 32'(face_ordinal));
          check_field("intrinsic_dim", 32'(want.intrinsic_dim), 32'(intrinsic_dim));
          check_field("boundary_total", 32'(want.boundary_total), 32'(boundary_total));
          check_field("is_center", 32'(want.is_center), 32'(is_center));
          check_field("boundary_ordinal", 32'(want.boundary_ordinal),
                      32'(boundary_ordinal));
        end
      end
      // pop first: the next item may start on the edge that ends the done cycle
      if (start === 1'b1 && busy === 1'b0)
        pending_faces.push_back(locate_boundary_face(face_dim, face_digits, bnd_index));
    end
    fail_count  <= mismatches;
    outstanding <= pending_faces.size();
  end

endmodule

// File: sim/testbench.sv
// stimulus and verdict for the face boundary ordinal core
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 220;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [cfbo_pkg::DIM_W-1:0]    face_dim = '0;
  logic [31:0]                   face_digits = '0;
  logic [cfbo_pkg::ORD_W-1:0]    bnd_index = '0;
  logic                          busy;
  logic                          done;
  logic [cfbo_pkg::STATUS_W-1:0] status;
  logic [cfbo_pkg::ORD_W-1:0]    face_ordinal;
  logic [cfbo_pkg::DIM_W-1:0]    intrinsic_dim;
  logic [cfbo_pkg::ORD_W-1:0]    boundary_total;
  logic                          is_center;
  logic [cfbo_pkg::ORD_W-1:0]    boundary_ordinal;
  int                            fail_count;
  int                            outstanding;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cube_face_boundary_ordinal_core DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .face_dim         (face_dim),
    .face_digits      (face_digits),
    .bnd_index        (bnd_index),
    .done             (done),
    .status           (status),
    .face_ordinal     (face_ordinal),
    .intrinsic_dim    (intrinsic_dim),
    .boundary_total   (boundary_total),
    .is_center        (is_center),
    .boundary_ordinal (boundary_ordinal)
  );

  cfbo_face_monitor face_monitor (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .face_dim         (face_dim),
    .face_digits      (face_digits),
    .bnd_index        (bnd_index),
    .done             (done),
    .status           (status),
    .face_ordinal     (face_ordinal),
    .intrinsic_dim    (intrinsic_dim),
    .boundary_total   (boundary_total),
    .is_center        (is_center),
    .boundary_ordinal (boundary_ordinal),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  // present one item, optionally after a random gap, and hold it until taken
  task automatic send_face(input logic [cfbo_pkg::DIM_W-1:0] dim, input logic [31:0] digits,
                           input logic [cfbo_pkg::ORD_W-1:0] idx, input int idle_pct);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 40);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    face_dim    <= dim;
    face_digits <= digits;
    bnd_index   <= idx;
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_all_results;
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // used axes get endpoints or varying digits; axes past the dimension get anything
  function automatic logic [31:0] random_face(input int n, input bit with_bad);
    logic [31:0] digits;
    int          vary_pct;
    vary_pct = $urandom_range(0, 100);
    digits = $urandom;
    for (int i = 0; i < n && i < cfbo_pkg::DIGIT_AXES; i++)
      digits[2*i +: 2] = ($urandom_range(99) < vary_pct) ? cfbo_pkg::DIGIT_VARYING :
                         2'($urandom_range(0, 1));
    if (with_bad && n > 0)
      digits[2*$urandom_range(0, (n > cfbo_pkg::DIGIT_AXES ? cfbo_pkg::DIGIT_AXES : n) - 1)
             +: 2] = cfbo_pkg::DIGIT_INVALID;
    return digits;
  endfunction

  // mostly in range, with the last index, the first one past it and wild values mixed in
  function automatic logic [cfbo_pkg::ORD_W-1:0] random_index(input int n,
                                                              input logic [31:0] digits);
    longint total;
    int     pick;
    total = 1;
    for (int i = 0; i < n && i < cfbo_pkg::DIGIT_AXES; i++)
      if (digits[2*i +: 2] == cfbo_pkg::DIGIT_VARYING) total = total * 3;
    total = total - 1;
    pick = $urandom_range(99);
    if (total == 0 || pick < 8) return cfbo_pkg::ORD_W'($urandom);
    if (pick < 13) return cfbo_pkg::ORD_W'(total - 1);
    if (pick < 18) return cfbo_pkg::ORD_W'(total);
    return cfbo_pkg::ORD_W'(longint'($urandom) % total);
  endfunction

  initial begin
    int idle_plan[4];
    int n;
    logic [31:0] digits;
    idle_plan = '{0, 68, 0, 37};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_face(5'd0,  32'h0000_0000, 26'd0, 0);          // empty face
    send_face(5'd0,  32'hFFFF_FFFF, 26'd0, 0);          // empty face ignores digits
    send_face(5'd16, 32'hAAAA_AAAA, 26'd0, 0);          // center face
    send_face(5'd16, 32'hAAAA_AAAA, 26'd43046719, 0);   // last boundary
    send_face(5'd16, 32'hAAAA_AAAA, 26'd43046720, 0);   // index equals count
    send_face(5'd16, 32'hAAAA_AAAA, 26'h3FF_FFFF, 0);
    send_face(5'd31, 32'hAAAA_AAAA, 26'd12345, 0);      // dimension saturates
    send_face(5'd17, 32'hAAAA_AAA9, 26'd14348905, 0);
    send_face(5'd31, 32'hFAAA_AAAA, 26'd5, 0);          // bad digit on top axis
    send_face(5'd16, 32'h0000_0000, 26'd0, 0);          // no varying axis
    send_face(5'd16, 32'h5555_5555, 26'd0, 0);
    send_face(5'd16, 32'h5555_5556, 26'd1, 0);
    send_face(5'd1,  32'h0000_0002, 26'd0, 0);
    send_face(5'd1,  32'h0000_0002, 26'd1, 0);
    send_face(5'd1,  32'h0000_0002, 26'd2, 0);
    send_face(5'd1,  32'h0000_0003, 26'd0, 0);          // bad digit on axis zero
    send_face(5'd3,  32'hFFFF_FFE6, 26'd7, 0);          // bad digits past the dimension
    send_face(5'd4,  32'h0000_000E, 26'd0, 0);          // bad digit after a varying one
    send_face(5'd16, 32'h7FFF_FFFF, 26'd0, 0);
    send_face(5'd8,  32'h0000_A5A6, 26'd20, 0);
    send_face(5'd2,  32'h0000_000A, 26'd3, 0);
    send_face(5'd2,  32'h0000_000A, 26'd7, 0);
    wait_all_results;

    foreach (idle_plan[p]) begin
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        n = ($urandom_range(99) < 85) ? $urandom_range(0, 16) : $urandom_range(17, 31);
        digits = random_face(n, $urandom_range(99) < 10);
        send_face(cfbo_pkg::DIM_W'(n), digits, random_index(n, digits), idle_plan[p]);
      end
      wait_all_results;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
